>>> design/frt_pkg.sv
// shared types, codes and defaults for the firewall rule table
package frt_pkg;

	localparam int DEFAULT_RULE_SLOTS = 16;

	localparam logic [1:0] FN_ADD   = 2'd0;
	localparam logic [1:0] FN_DEL   = 2'd1;
	localparam logic [1:0] FN_CHECK = 2'd2;

	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_DELETED  = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_ACCEPTED = 3'd5;
	localparam logic [2:0] ST_REJECTED = 3'd6;

	typedef struct packed {
		logic [31:0] ip_start;
		logic [31:0] ip_end;
		logic [15:0] port_start;
		logic [15:0] port_end;
		logic        ip_rng;
		logic        port_rng;
	} rule_t;

	typedef struct packed {
		logic equal;
		logic covers;
	} cmp_res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_SH_RD,
		S_SH_WR,
		S_DONE
	} frt_state_t;

endpackage

>>> design/frt_rule_mem.sv
// rule storage: one write port, one registered read port
module frt_rule_mem import frt_pkg::*; #(
	parameter int RULE_SLOTS = DEFAULT_RULE_SLOTS,
	parameter int IW = $clog2(RULE_SLOTS)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] wr_addr,
	input  rule_t         wr_data,
	input  logic [IW-1:0] rd_addr,
	output rule_t         rd_data
);

	rule_t mem [RULE_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> design/frt_cmp.sv
// shared compare unit: exact rule match and address/port coverage
module frt_cmp import frt_pkg::*; (
	input  rule_t    entry,
	input  rule_t    req,
	output cmp_res_t res
);

	logic ip_eq;
	logic port_eq;
	logic ip_cov;
	logic port_cov;

	always_comb begin
		ip_eq = (entry.ip_rng == req.ip_rng) && (entry.ip_start == req.ip_start) &&
			(!entry.ip_rng || (entry.ip_end == req.ip_end));
		port_eq = (entry.port_rng == req.port_rng) && (entry.port_start == req.port_start) &&
			(!entry.port_rng || (entry.port_end == req.port_end));
		if (entry.ip_rng) begin
			ip_cov = (req.ip_start >= entry.ip_start) && (req.ip_start <= entry.ip_end);
		end else begin
			ip_cov = (req.ip_start == entry.ip_start);
		end
		port_cov = (req.port_start >= entry.port_start) && (req.port_start <= entry.port_end);
		res.equal  = ip_eq && port_eq;
		res.covers = ip_cov && port_cov;
	end

endmodule

>>> design/firewall_rule_table_core.sv
// firewall rule table: add, delete and newest-first check over stored rules
// add, invalid and unused codes, and scans of an empty table, go straight to the result
// check/delete: read then compare per rule scanned; a delete hit shifts each newer rule down
// one rule memory read port and one compare unit serve every scan and shift step
// s_tready is high only in idle: no new word until the last result enters the output register
// reset (arst_n low, async) empties the table; rule memory contents are not cleared
module firewall_rule_table_core import frt_pkg::*; #(
	parameter int RULE_SLOTS = DEFAULT_RULE_SLOTS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// ip_first[31:0], ip_last[63:32], ip_ranged[64], port_first[80:65],
	// port_last[96:81], port_ranged[97], zero pad
	input  logic [103:0] s_tdata,
	// func[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], zero pad
	output logic [7:0]   m_tdata
);

	localparam int IW  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int CW  = $clog2(RULE_SLOTS + 1);
	localparam int CW1 = CW + 1;

	frt_state_t state_q, state_d;

	rule_t          req_q;
	logic [1:0]     func_q;
	logic [IW-1:0]  idx_q;
	logic [CW-1:0]  count_q;
	logic [2:0]     res_q;
	logic           out_valid_q;
	logic [2:0]     out_status_q;

	rule_t          in_rule;
	rule_t          rd_data;
	rule_t          wr_data;
	logic           mem_we;
	logic [IW-1:0]  wr_addr;
	logic [IW-1:0]  rd_addr;
	cmp_res_t       cmp_res;

	logic           accept;
	logic           port_bad;
	logic           full;
	logic           empty;
	logic           idle_scan;
	logic           add_wr;
	logic [2:0]     idle_res;
	logic [CW-1:0]  cnt_m1;
	logic           hit;
	logic           more_cmp;
	logic           more_sh;
	logic           load;

	always_comb begin
		in_rule.ip_start   = s_tdata[31:0];
		in_rule.ip_rng     = s_tdata[64];
		in_rule.ip_end     = s_tdata[64] ? s_tdata[63:32] : s_tdata[31:0];
		in_rule.port_start = s_tdata[80:65];
		in_rule.port_rng   = s_tdata[97];
		in_rule.port_end   = s_tdata[97] ? s_tdata[96:81] : s_tdata[80:65];
	end

	frt_rule_mem #(
		.RULE_SLOTS (RULE_SLOTS),
		.IW         (IW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	frt_cmp u_cmp (
		.entry (rd_data),
		.req   (req_q),
		.res   (cmp_res)
	);

	// decisions made on the incoming word and the scan step
	always_comb begin
		accept   = s_tvalid && s_tready;
		port_bad = s_tdata[97] && !(s_tdata[80:65] < s_tdata[96:81]);
		full     = (count_q == CW'(RULE_SLOTS));
		empty    = (count_q == '0);
		cnt_m1   = count_q - CW'(1);
		unique case (s_tuser)
			FN_ADD: begin
				idle_scan = 1'b0;
				idle_res  = port_bad ? ST_INVALID : (full ? ST_FULL : ST_ADDED);
			end
			FN_DEL: begin
				idle_scan = !port_bad && !empty;
				idle_res  = port_bad ? ST_INVALID : ST_NOTFOUND;
			end
			FN_CHECK: begin
				idle_scan = !empty;
				idle_res  = ST_REJECTED;
			end
			default: begin
				idle_scan = 1'b0;
				idle_res  = ST_INVALID;
			end
		endcase
		add_wr   = accept && (s_tuser == FN_ADD) && !port_bad && !full;
		hit      = (func_q == FN_CHECK) ? cmp_res.covers : cmp_res.equal;
		more_cmp = (CW1'(idx_q) + CW1'(1)) < CW1'(count_q);
		more_sh  = (CW1'(idx_q) + CW1'(2)) < CW1'(count_q);
		load     = (state_q == S_DONE) && (!out_valid_q || m_tready);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = idle_scan ? S_RD : S_DONE;
				end
			end
			S_RD: state_d = S_CMP;
			S_CMP: begin
				if (hit) begin
					state_d = ((func_q == FN_DEL) && more_cmp) ? S_SH_RD : S_DONE;
				end else begin
					state_d = (idx_q == '0) ? S_DONE : S_RD;
				end
			end
			S_SH_RD: state_d = S_SH_WR;
			S_SH_WR: state_d = more_sh ? S_SH_RD : S_DONE;
			S_DONE: begin
				if (load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = (state_q == S_IDLE);
		mem_we   = 1'b0;
		wr_addr  = idx_q;
		wr_data  = rd_data;
		rd_addr  = idx_q;
		unique case (state_q)
			S_IDLE: begin
				mem_we  = add_wr;
				wr_addr = count_q[IW-1:0];
				wr_data = in_rule;
			end
			S_SH_RD: rd_addr = idx_q + IW'(1);
			S_SH_WR: mem_we = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (add_wr) begin
				count_q <= count_q + CW'(1);
			end else if ((state_q == S_CMP) && hit && (func_q == FN_DEL) && !more_cmp) begin
				count_q <= cnt_m1;
			end else if ((state_q == S_SH_WR) && !more_sh) begin
				count_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q  <= in_rule;
					func_q <= s_tuser;
					idx_q  <= cnt_m1[IW-1:0];
					res_q  <= idle_res;
				end
			end
			S_CMP: begin
				if (hit) begin
					res_q <= (func_q == FN_CHECK) ? ST_ACCEPTED : ST_DELETED;
				end else if (idx_q == '0) begin
					res_q <= (func_q == FN_CHECK) ? ST_REJECTED : ST_NOTFOUND;
				end else begin
					idx_q <= idx_q - IW'(1);
				end
			end
			S_SH_WR: idx_q <= idx_q + IW'(1);
			default: begin
			end
		endcase
	end

	// output register parts the result from the next incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_status_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW1'(count_q) <= CW1'(RULE_SLOTS))
		else $error("rule count above table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
		(count_q == $past(count_q) - CW'(1)))
		else $error("rule count moved by more than one");

	a_shift_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SH_WR) |-> ((CW1'(idx_q) + CW1'(1)) < CW1'(count_q)))
		else $error("shift write outside stored rules");

	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) && hit && (func_q == FN_CHECK) |=> (state_q == S_DONE))
		else $error("check hit did not finish");

endmodule

>>> bench/tb.sv
// testbench for firewall_rule_table_core: directed and random rule table traffic against a predictor
`timescale 1ns / 100ps

module tb;
	import frt_pkg::*;

	localparam int          RULE_SLOTS = DEFAULT_RULE_SLOTS;
	localparam logic [1:0]  FN_UNUSED  = 2'd3;
	localparam int          HOLD_CYCLES = 300;
	localparam int          DRAIN_CYCLES = 100;
	localparam int          MAX_REPORTS = 10;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] ip_first;
		logic [31:0] ip_last;
		logic        ip_ranged;
		logic [15:0] port_first;
		logic [15:0] port_last;
		logic        port_ranged;
	} request_t;

	typedef struct {
		logic [31:0] ip_lo;
		logic [31:0] ip_hi;
		logic [15:0] port_lo;
		logic [15:0] port_hi;
		logic        ip_rng;
		logic        port_rng;
	} filter_rule_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [7:0]   m_tdata;

	filter_rule_t rule_table[$];
	logic [2:0]   status_due[$];
	logic [2:0]   status_want;
	int           status_seen[8];
	int           requests_sent;
	int           mismatch_count;
	int           src_idle_pct;
	int           sink_idle_pct;
	logic         sink_held = 1'b0;
	event         hold_go;

	firewall_rule_table_core #(
		.RULE_SLOTS(RULE_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predicted status of one request; updates the predicted rule table
	function automatic logic [2:0] apply_request(input request_t r);
		filter_rule_t nr;
		logic [31:0]  ip_end;
		logic [15:0]  port_end;
		logic         bad_ports;
		int           i;
		ip_end = r.ip_ranged ? r.ip_last : r.ip_first;
		port_end = r.port_ranged ? r.port_last : r.port_first;
		bad_ports = r.port_ranged && !(r.port_first < port_end);
		case (r.op)
			FN_ADD: begin
				if (bad_ports)
					return ST_INVALID;
				if (rule_table.size() >= RULE_SLOTS)
					return ST_FULL;
				nr.ip_lo = r.ip_first;
				nr.ip_hi = ip_end;
				nr.port_lo = r.port_first;
				nr.port_hi = port_end;
				nr.ip_rng = r.ip_ranged;
				nr.port_rng = r.port_ranged;
				rule_table.push_back(nr);
				return ST_ADDED;
			end
			FN_DEL: begin
				if (bad_ports)
					return ST_INVALID;
				for (i = rule_table.size() - 1; i >= 0; i--) begin
					nr = rule_table[i];
					if (nr.ip_rng == r.ip_ranged && nr.ip_lo == r.ip_first &&
							(!nr.ip_rng || nr.ip_hi == ip_end) &&
							nr.port_rng == r.port_ranged && nr.port_lo == r.port_first &&
							(!nr.port_rng || nr.port_hi == port_end)) begin
						rule_table.delete(i);
						return ST_DELETED;
					end
				end
				return ST_NOTFOUND;
			end
			FN_CHECK: begin
				for (i = rule_table.size() - 1; i >= 0; i--) begin
					nr = rule_table[i];
					if ((nr.ip_rng ? (r.ip_first >= nr.ip_lo && r.ip_first <= nr.ip_hi)
							: r.ip_first == nr.ip_lo) &&
							r.port_first >= nr.port_lo && r.port_first <= nr.port_hi)
						return ST_ACCEPTED;
				end
				return ST_REJECTED;
			end
			default: return ST_INVALID;
		endcase
	endfunction

	task automatic send_request(input request_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct && gap < 20)
			gap++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.op;
		s_tdata <= {6'd0, r.port_ranged, r.port_last, r.port_first, r.ip_ranged,
			r.ip_last, r.ip_first};
		do
			@(posedge clk);
		while (!s_tready);
		requests_sent++;
		status_due.push_back(apply_request(r));
	endtask

	task automatic send_fields(input logic [1:0] op, input logic [31:0] ipf,
			input logic [31:0] ipl, input logic ipr, input logic [15:0] pf,
			input logic [15:0] pl, input logic pr);
		request_t r;
		r.op = op;
		r.ip_first = ipf;
		r.ip_last = ipl;
		r.ip_ranged = ipr;
		r.port_first = pf;
		r.port_last = pl;
		r.port_ranged = pr;
		send_request(r);
	endtask

	// sender stops offering until every outstanding result is back
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (status_due.size() != 0)
			@(posedge clk);
	endtask

	// a few addresses and ports cluster so rules overlap and get hit
	function automatic logic [31:0] pick_ip();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2, 3: return $urandom;
			default: return 32'hC0A8_0000 | $urandom_range(15);
		endcase
	endfunction

	function automatic logic [15:0] pick_port();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(16'hFFFF));
			default: return 16'($urandom_range(40, 20));
		endcase
	endfunction

	function automatic request_t random_rule_request(input logic [1:0] op);
		request_t r;
		r.op = op;
		r.ip_first = pick_ip();
		r.ip_ranged = 1'($urandom_range(1));
		if (r.ip_ranged)
			r.ip_last = ($urandom_range(9) == 0) ? pick_ip() : r.ip_first + $urandom_range(12);
		else
			r.ip_last = $urandom;
		r.port_first = pick_port();
		r.port_ranged = 1'($urandom_range(1));
		if (r.port_ranged)
			r.port_last = ($urandom_range(9) == 0) ? pick_port()
				: 16'(r.port_first + $urandom_range(30, 1));
		else
			r.port_last = 16'($urandom_range(16'hFFFF));
		return r;
	endfunction

	// request aimed at stored rule k: exact copy for delete, a point inside for check
	function automatic request_t request_from_rule(input logic [1:0] op, input int k);
		request_t     r;
		filter_rule_t nr;
		nr = rule_table[k];
		r = random_rule_request(op);
		r.ip_first = nr.ip_lo;
		r.port_first = nr.port_lo;
		if (op == FN_CHECK) begin
			if (nr.ip_rng && nr.ip_hi > nr.ip_lo)
				r.ip_first = nr.ip_lo + $urandom_range(nr.ip_hi - nr.ip_lo);
			r.port_first = 16'(nr.port_lo + $urandom_range(nr.port_hi - nr.port_lo));
		end else begin
			r.ip_ranged = nr.ip_rng;
			r.port_ranged = nr.port_rng;
			if (nr.ip_rng)
				r.ip_last = nr.ip_hi;
			if (nr.port_rng)
				r.port_last = nr.port_hi;
		end
		// near misses now and then
		case ($urandom_range(7))
			0: r.ip_first = r.ip_first + 32'd1;
			1: r.port_first = r.port_first - 16'd1;
			default: ;
		endcase
		return r;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int       sel;
		int       add_pct;
		sel = $urandom_range(99);
		add_pct = (rule_table.size() < 10) ? 45 : 25;
		if (sel < 4) begin
			r = random_rule_request(FN_UNUSED);
			r.ip_last = $urandom;
		end else if (sel < 4 + add_pct) begin
			r = random_rule_request(FN_ADD);
		end else if (sel < 30 + add_pct) begin
			if (rule_table.size() != 0 && $urandom_range(3) != 0)
				r = request_from_rule(FN_DEL, $urandom_range(rule_table.size() - 1));
			else
				r = random_rule_request(FN_DEL);
		end else begin
			if (rule_table.size() != 0 && $urandom_range(3) != 0)
				r = request_from_rule(FN_CHECK, $urandom_range(rule_table.size() - 1));
			else
				r = random_rule_request(FN_CHECK);
		end
		return r;
	endfunction

	task automatic test_directed();
		send_fields(FN_CHECK, 32'h0, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0);
		send_fields(FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
		// single address and port, ignored ends carry garbage
		send_fields(FN_ADD, 32'h0, 32'hFFFF_FFFF, 1'b0, 16'h0, 16'hFFFF, 1'b0);
		send_fields(FN_CHECK, 32'h0, 32'h1234_5678, 1'b1, 16'h0, 16'h00FF, 1'b1);
		send_fields(FN_CHECK, 32'h1, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0);
		send_fields(FN_CHECK, 32'h0, 32'h0, 1'b0, 16'h1, 16'h0, 1'b0);
		send_fields(FN_ADD, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1, 16'hFFFE, 16'hFFFF, 1'b1);
		send_fields(FN_CHECK, 32'hFFFF_FFFF, 32'h0, 1'b0, 16'hFFFF, 16'h0, 1'b0);
		send_fields(FN_CHECK, 32'hFFFF_FEFF, 32'h0, 1'b0, 16'hFFFF, 16'h0, 1'b0);
		// port range must have start below end, on add and on delete
		send_fields(FN_ADD, 32'h0A00_0001, 32'h0, 1'b0, 16'd80, 16'd80, 1'b1);
		send_fields(FN_ADD, 32'h0A00_0001, 32'h0, 1'b0, 16'd90, 16'd80, 1'b1);
		send_fields(FN_DEL, 32'h0, 32'h0, 1'b0, 16'hFFFF, 16'h0, 1'b1);
		// reversed address range matches nothing
		send_fields(FN_ADD, 32'h0A00_0009, 32'h0A00_0001, 1'b1, 16'd22, 16'd0, 1'b0);
		send_fields(FN_CHECK, 32'h0A00_0005, 32'h0, 1'b0, 16'd22, 16'd0, 1'b0);
		send_fields(FN_CHECK, 32'h0A00_0009, 32'h0, 1'b0, 16'd22, 16'd0, 1'b0);
		send_fields(FN_DEL, 32'h0, 32'h5555_5555, 1'b0, 16'h0, 16'hAAAA, 1'b0);
		send_fields(FN_CHECK, 32'h0, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0);
		send_fields(FN_DEL, 32'h0, 32'h0, 1'b0, 16'h0, 16'h0, 1'b0);
		// ranged delete: wrong end, then wrong flag, then exact
		send_fields(FN_DEL, 32'hFFFF_FF00, 32'hFFFF_FFFE, 1'b1, 16'hFFFE, 16'hFFFF, 1'b1);
		send_fields(FN_DEL, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b0, 16'hFFFE, 16'hFFFF, 1'b1);
		send_fields(FN_DEL, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1, 16'hFFFE, 16'hFFFF, 1'b1);
		// duplicate rules: deleting one leaves the other
		send_fields(FN_ADD, 32'h0102_0304, 32'h0, 1'b0, 16'd443, 16'd0, 1'b0);
		send_fields(FN_ADD, 32'h0102_0304, 32'h0, 1'b0, 16'd443, 16'd0, 1'b0);
		send_fields(FN_DEL, 32'h0102_0304, 32'h0, 1'b0, 16'd443, 16'd0, 1'b0);
		send_fields(FN_CHECK, 32'h0102_0304, 32'h0, 1'b0, 16'd443, 16'd0, 1'b0);
		wait_results_done();
	endtask

	task automatic test_table_fill();
		request_t r;
		while (rule_table.size() < RULE_SLOTS) begin
			r = random_rule_request(FN_ADD);
			r.port_ranged = 1'b0;
			send_request(r);
		end
		send_request(random_rule_request(FN_ADD));
		send_fields(FN_ADD, 32'h0, 32'h0, 1'b0, 16'd7, 16'd3, 1'b1);
		send_request(request_from_rule(FN_CHECK, 0));
		// removal from the middle shifts the newer rules down
		send_request(request_from_rule(FN_DEL, RULE_SLOTS / 2));
		send_request(request_from_rule(FN_CHECK, RULE_SLOTS / 2));
		send_request(request_from_rule(FN_DEL, 0));
		send_request(request_from_rule(FN_DEL, rule_table.size() - 1));
		send_request(random_rule_request(FN_ADD));
		wait_results_done();
	endtask

	task automatic test_random(input int count);
		repeat (count)
			send_request(random_request());
		wait_results_done();
	endtask

	// receiver stalls for a long stretch while requests keep coming
	task automatic test_backpressure(input int count);
		-> hold_go;
		repeat (count)
			send_request(random_request());
		wait_results_done();
	endtask

	always begin
		@(hold_go);
		@(posedge clk);
		sink_held <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_held <= 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= !sink_held && ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic report_mismatch(input string what, input logic [2:0] want,
			input logic [7:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%t: %s: expected status %0d, got %0d", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (status_due.size() == 0) begin
				report_mismatch("word with no request pending", 3'd0, m_tdata);
			end else begin
				status_want = status_due.pop_front();
				if (m_tdata[2:0] !== status_want)
					report_mismatch("status", status_want, m_tdata);
			end
			if (!$isunknown(m_tdata[2:0]))
				status_seen[m_tdata[2:0]]++;
		end
	end

	initial begin
		#8_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= FN_ADD;
		requests_sent = 0;
		mismatch_count = 0;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_fill();
		src_idle_pct = 15;
		sink_idle_pct = 70;
		test_random(500);
		test_backpressure(40);
		src_idle_pct = 70;
		sink_idle_pct = 15;
		test_random(500);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random(500);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (status_due.size() != 0) begin
			$display("%0d results never arrived", status_due.size());
			mismatch_count += status_due.size();
		end
		$display("%0d requests: %0d added, %0d invalid, %0d full, %0d deleted, %0d not found",
			requests_sent, status_seen[ST_ADDED], status_seen[ST_INVALID],
			status_seen[ST_FULL], status_seen[ST_DELETED], status_seen[ST_NOTFOUND]);
		$display("checks: %0d accepted, %0d rejected; %0d mismatches",
			status_seen[ST_ACCEPTED], status_seen[ST_REJECTED], mismatch_count);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
